### rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types, constants and hash helpers for the Bloom filter engine.
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int unsigned MAX_FILTER_BITS = 65536;
  localparam int unsigned MAX_PROBES      = 32;
  localparam int unsigned WORD_COUNT      = (MAX_FILTER_BITS + 63) / 64;
  localparam int unsigned WORD_AW         = $clog2(WORD_COUNT);
  localparam int unsigned POS_W           = $clog2(MAX_FILTER_BITS);
  localparam int unsigned BITS_W          = 17;
  localparam int unsigned PROBES_W        = 6;
  localparam int unsigned DIV_STEPS       = 16;   // 64-bit dividend, 4 bits per cycle

  localparam logic [63:0] SEED_A = 64'd2166136261;
  localparam logic [63:0] SEED_B = 64'hcbf2_9ce4_8422_2325 ^ 64'h0000_0000_dead_beef;

  localparam logic [BITS_W-1:0]   BITS_RESET   = BITS_W'(MAX_FILTER_BITS);
  localparam logic [PROBES_W-1:0] PROBES_RESET = PROBES_W'(7);

  localparam logic CFG_IDX_BITS   = 1'b0;
  localparam logic CFG_IDX_PROBES = 1'b1;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic        is_clear;
    logic        ins;
    logic [63:0] ha;
    logic [63:0] hb;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_DONE
  } back_state_t;

  // x * 16777619 = x * (2^24 + 0x193)
  function automatic logic [63:0] mul_a(input logic [63:0] x);
    mul_a = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

  // x * 0x00000100000001B3 = x * (2^40 + 0x1B3)
  function automatic logic [63:0] mul_b(input logic [63:0] x);
    mul_b = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Four restoring remainder steps; r < m on entry and exit
  function automatic logic [BITS_W-1:0] rem_step(input logic [BITS_W-1:0] r,
                                                 input logic [3:0]        d,
                                                 input logic [BITS_W-1:0] m);
    logic [BITS_W:0]   t;
    logic [BITS_W-1:0] rr;
    rr = r;
    for (int j = 3; j >= 0; j--) begin
      t = {rr, d[j]};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      rr = t[BITS_W-1:0];
    end
    rem_step = rr;
  endfunction

  function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] v);
    if (v == '0) eff_bits = BITS_W'(1);
    else if (v > BITS_W'(MAX_FILTER_BITS)) eff_bits = BITS_W'(MAX_FILTER_BITS);
    else eff_bits = v;
  endfunction

  function automatic logic [PROBES_W-1:0] eff_probes(input logic [PROBES_W-1:0] v);
    if (v == '0) eff_probes = PROBES_W'(1);
    else if (v > PROBES_W'(MAX_PROBES)) eff_probes = PROBES_W'(MAX_PROBES);
    else eff_probes = v;
  endfunction

endpackage

### rtl/bloom_filter_engine_core.sv
// ----------------------------------------------------------------------------
// bloom_filter_engine_core
// Bloom filter engine with two FNV-1a style hashes and double-hashed probes.
// ----------------------------------------------------------------------------
// Key bytes are hashed at one per cycle while busy is low; a last byte or a
// clear goes into a two-entry queue for the probe back end. Each probe there
// runs 4-bit remainder steps, then a bit store read, then an update. start is
// refused (busy) while the queue is full or the sweep after reset runs.
// Clears and reset sweep the 1024-word bit store at one word per cycle; busy
// is held through the sweep after reset. Results come out as a one-cycle
// out_valid pulse and cannot be stalled.
module bloom_filter_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic        in_do_insert,
  output logic        out_valid,
  output logic        out_was_insert,
  output logic        out_present,
  output logic [31:0] out_item_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfe_pkg::*;

  logic [BITS_W-1:0]   bits_r;
  logic [PROBES_W-1:0] probes_r;
  logic                accept, push, q_pop, q_empty, q_full, init_busy;
  q_entry_t            push_data, q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_PROBES) ? {{(32-PROBES_W){1'b0}}, probes_r}
                                               : {{(32-BITS_W){1'b0}}, bits_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= BITS_RESET;
      probes_r <= PROBES_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_IDX_BITS) bits_r <= pwdata[BITS_W-1:0];
      else probes_r <= pwdata[PROBES_W-1:0];
    end
  end

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  bfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_kind),
    .key_byte  (in_key_byte),
    .last_byte (in_last_byte),
    .do_insert (in_do_insert),
    .push      (push),
    .push_data (push_data)
  );

  bfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .pop_data  (q_data)
  );

  bfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .bit_count      (bits_r),
    .probe_count    (probes_r),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .res_valid      (out_valid),
    .res_was_insert (out_was_insert),
    .res_present    (out_present),
    .res_item_count (out_item_count)
  );

endmodule

### rtl/bfe_front.sv
// ----------------------------------------------------------------------------
// bfe_front
// Byte hashing front end: folds key bytes into both hashes, queues keys/clears.
// ----------------------------------------------------------------------------
module bfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              kind,
  input  logic [7:0]        key_byte,
  input  logic              last_byte,
  input  logic              do_insert,
  output logic              push,
  output bfe_pkg::q_entry_t push_data
);
  import bfe_pkg::*;

  logic [63:0] ha_r, ha_nxt;
  logic [63:0] hb_r, hb_nxt;
  logic [63:0] ha_new, hb_new;

  assign ha_new = mul_a(ha_r ^ {56'd0, key_byte});
  assign hb_new = mul_b(hb_r ^ {56'd0, key_byte});

  always_comb begin
    ha_nxt             = ha_r;
    hb_nxt             = hb_r;
    push               = 1'b0;
    push_data.is_clear = (kind == KIND_CLEAR);
    push_data.ins      = do_insert;
    push_data.ha       = ha_new;
    push_data.hb       = hb_new;
    if (accept) begin
      if (kind == KIND_CLEAR) begin
        ha_nxt = SEED_A;
        hb_nxt = SEED_B;
        push   = 1'b1;
      end else if (last_byte) begin
        ha_nxt = SEED_A;
        hb_nxt = SEED_B;
        push   = 1'b1;
      end else begin
        ha_nxt = ha_new;
        hb_nxt = hb_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ha_r <= SEED_A;
      hb_r <= SEED_B;
    end else begin
      ha_r <= ha_nxt;
      hb_r <= hb_nxt;
    end
  end

endmodule

### rtl/bfe_queue.sv
// ----------------------------------------------------------------------------
// bfe_queue
// Two-entry queue between hashing front end and probe back end.
// ----------------------------------------------------------------------------
module bfe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfe_pkg::q_entry_t push_data,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output bfe_pkg::q_entry_t pop_data
);
  import bfe_pkg::*;

  q_entry_t   slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/bfe_back.sv
// ----------------------------------------------------------------------------
// bfe_back
// Probe back end: per-probe modulo, bit store read (and write on insert), clear sweeps.
// ----------------------------------------------------------------------------
module bfe_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bfe_pkg::BITS_W-1:0]      bit_count,
  input  logic [bfe_pkg::PROBES_W-1:0]    probe_count,
  input  logic                            q_empty,
  input  bfe_pkg::q_entry_t               q_data,
  output logic                            q_pop,
  output logic                            init_busy,
  output logic                            res_valid,
  output logic                            res_was_insert,
  output logic                            res_present,
  output logic [31:0]                     res_item_count
);
  import bfe_pkg::*;

  back_state_t         st_r, st_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [63:0]         hb_r, hb_nxt;
  logic [63:0]         dq_r, dq_nxt;
  logic [BITS_W-1:0]   rem_r, rem_nxt;
  logic [3:0]          cyc_r, cyc_nxt;
  logic [PROBES_W-1:0] pi_r, pi_nxt;
  logic                ins_r, ins_nxt;
  logic                all_r, all_nxt;
  logic [WORD_AW-1:0]  clr_r, clr_nxt;
  logic [31:0]         cnt_r, cnt_nxt;
  logic                vld_r, vld_nxt;
  logic                wi_r, wi_nxt;
  logic                pr_r, pr_nxt;

  logic [BITS_W-1:0]   m_eff;
  logic [PROBES_W-1:0] k_eff;

  logic [63:0]         mem [WORD_COUNT];
  logic [63:0]         rdata_r;
  logic                mem_we, mem_re;
  logic [WORD_AW-1:0]  mem_wa, mem_ra;
  logic [63:0]         mem_wd;

  assign m_eff          = eff_bits(bit_count);
  assign k_eff          = eff_probes(probe_count);
  assign init_busy      = (st_r == ST_INIT);
  assign res_valid      = vld_r;
  assign res_was_insert = wi_r;
  assign res_present    = pr_r;
  assign res_item_count = cnt_r;

  always_comb begin
    st_nxt  = st_r;
    acc_nxt = acc_r;
    hb_nxt  = hb_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    cyc_nxt = cyc_r;
    pi_nxt  = pi_r;
    ins_nxt = ins_r;
    all_nxt = all_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    vld_nxt = 1'b0;
    wi_nxt  = wi_r;
    pr_nxt  = pr_r;
    q_pop   = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = clr_r;
    mem_ra  = rem_r[POS_W-1:6];
    mem_wd  = '0;
    case (st_r)
      ST_INIT, ST_CLR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + WORD_AW'(1);
        if (clr_r == WORD_AW'(WORD_COUNT - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.is_clear) begin
            cnt_nxt = '0;
            clr_nxt = '0;
            st_nxt  = ST_CLR;
          end else begin
            ins_nxt = q_data.ins;
            acc_nxt = q_data.ha;
            hb_nxt  = q_data.hb;
            dq_nxt  = q_data.ha;
            rem_nxt = '0;
            cyc_nxt = '0;
            pi_nxt  = '0;
            all_nxt = 1'b1;
            st_nxt  = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        rem_nxt = rem_step(rem_r, dq_r[63:60], m_eff);
        dq_nxt  = dq_r << 4;
        cyc_nxt = cyc_r + 4'd1;
        if (cyc_r == 4'(DIV_STEPS - 1)) st_nxt = ST_RD;
      end
      ST_RD: begin
        mem_re = 1'b1;
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (ins_r) begin
          mem_we = 1'b1;
          mem_wa = rem_r[POS_W-1:6];
          mem_wd = rdata_r | (64'd1 << rem_r[5:0]);
        end else if (!rdata_r[rem_r[5:0]]) begin
          all_nxt = 1'b0;
        end
        pi_nxt  = pi_r + PROBES_W'(1);
        acc_nxt = acc_r + hb_r;
        if (pi_nxt == k_eff) begin
          st_nxt = ST_DONE;
        end else begin
          dq_nxt  = acc_r + hb_r;
          rem_nxt = '0;
          cyc_nxt = '0;
          st_nxt  = ST_MOD;
        end
      end
      ST_DONE: begin
        if (ins_r && cnt_r != 32'hFFFF_FFFF) cnt_nxt = cnt_r + 32'd1;
        vld_nxt = 1'b1;
        wi_nxt  = ins_r;
        pr_nxt  = !ins_r && all_r;
        st_nxt  = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    hb_r  <= hb_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    wi_r  <= wi_nxt;
    pr_r  <= pr_nxt;
    ins_r <= ins_nxt;
    all_r <= all_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_INIT;
      cyc_r <= '0;
      pi_r  <= '0;
      clr_r <= '0;
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cyc_r <= cyc_nxt;
      pi_r  <= pi_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

### tb/bfe_checker.sv
// ----------------------------------------------------------------------------
// bfe_checker
// Watches the item, result and register channels of the Bloom filter engine.
// It keeps its own filter state, predicts each result and compares it.
// ----------------------------------------------------------------------------
module bfe_checker
  import bfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic        in_do_insert,
  input  logic        out_valid,
  input  logic        out_was_insert,
  input  logic        out_present,
  input  logic [31:0] out_item_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ADDR_BITS   = 3'd0;
  localparam logic [2:0]  ADDR_PROBES = 3'd4;
  localparam logic [63:0] MULT_A      = 64'd16777619;
  localparam logic [63:0] MULT_B      = 64'h0000_0100_0000_01B3;

  typedef struct {
    logic        was_insert;
    logic        present;
    logic [31:0] item_count;
  } lookup_outcome_t;

  lookup_outcome_t             outcome_q[$];
  logic [MAX_FILTER_BITS-1:0]  filter_bits;
  logic [63:0]                 hash_a, hash_b;
  logic [31:0]                 key_total;
  logic [BITS_W-1:0]           cfg_bits;
  logic [PROBES_W-1:0]         cfg_probes;

  assign pending = outcome_q.size();

  function automatic logic [63:0] modulus(input logic [BITS_W-1:0] v);
    if (v == '0) return 64'd1;
    if (v > BITS_W'(MAX_FILTER_BITS)) return 64'(MAX_FILTER_BITS);
    return 64'(v);
  endfunction

  function automatic int unsigned probe_total(input logic [PROBES_W-1:0] v);
    if (v == '0) return 1;
    if (v > PROBES_W'(MAX_PROBES)) return MAX_PROBES;
    return v;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    logic [63:0]     na, nb, m, pos;
    logic            all_set;
    lookup_outcome_t exp_o;
    if (!rst_n) begin
      filter_bits = '0;
      key_total   = '0;
      hash_a      = SEED_A;
      hash_b      = SEED_B;
      cfg_bits    = BITS_RESET;
      cfg_probes  = PROBES_RESET;
      outcome_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_BITS) cfg_bits = pwdata[BITS_W-1:0];
        else if (paddr == ADDR_PROBES) cfg_probes = pwdata[PROBES_W-1:0];
      end
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: ins=%0b present=%0b count=%0d",
                                         out_was_insert, out_present, out_item_count);
        end else begin
          exp_o = outcome_q.pop_front();
          if (out_was_insert !== exp_o.was_insert || out_present !== exp_o.present ||
              out_item_count !== exp_o.item_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ins=%0b present=%0b count=%0d, got %0b %0b %0d",
                       exp_o.was_insert, exp_o.present, exp_o.item_count,
                       out_was_insert, out_present, out_item_count);
          end
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_CLEAR) begin
          filter_bits = '0;
          key_total   = '0;
          hash_a      = SEED_A;
          hash_b      = SEED_B;
        end else begin
          na = (hash_a ^ 64'(in_key_byte)) * MULT_A;
          nb = (hash_b ^ 64'(in_key_byte)) * MULT_B;
          hash_a = na;
          hash_b = nb;
          if (in_last_byte) begin
            m = modulus(cfg_bits);
            all_set = 1'b1;
            for (int unsigned i = 0; i < probe_total(cfg_probes); i++) begin
              pos = (na + 64'(i) * nb) % m;
              if (in_do_insert) filter_bits[pos[15:0]] = 1'b1;
              else if (!filter_bits[pos[15:0]]) all_set = 1'b0;
            end
            if (in_do_insert && key_total != 32'hFFFF_FFFF) key_total++;
            exp_o.was_insert = in_do_insert;
            exp_o.present    = !in_do_insert && all_set;
            exp_o.item_count = key_total;
            outcome_q.push_back(exp_o);
            hash_a = SEED_A;
            hash_b = SEED_B;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Bloom filter engine: directed keys, then random keys over
// several filter sizes and probe counts; bfe_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import bfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // covers a clear being swept plus two more clears waiting in the queue
  localparam int DRAIN_CYCLES = 3200;

  localparam logic [2:0] ADDR_BITS   = {CFG_IDX_BITS, 2'b00};
  localparam logic [2:0] ADDR_PROBES = {CFG_IDX_PROBES, 2'b00};

  logic        clk, rst_n, start, busy;
  logic        in_kind, in_last_byte, in_do_insert;
  logic [7:0]  in_key_byte;
  logic        out_valid, out_was_insert, out_present;
  logic [31:0] out_item_count;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          mismatches, pending;
  int          sent;

  logic [7:0]  recent_keys[16][12];
  int          recent_len[16];

  bloom_filter_engine_core u_dut (.*);

  bfe_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] kbyte,
                           input logic last, input logic ins, input bit idle_ok);
    int gap;
    start        <= 1'b1;
    in_kind      <= kind;
    in_key_byte  <= kbyte;
    in_last_byte <= last;
    in_do_insert <= ins;
    do @(posedge clk); while (busy);
    sent++;
    gap = idle_ok ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_key(input int slot, input logic ins, input bit idle_ok);
    for (int i = 0; i < recent_len[slot]; i++)
      send_item(KIND_KEY, recent_keys[slot][i], i == recent_len[slot] - 1,
                (i == recent_len[slot] - 1) ? ins : logic'($urandom_range(0, 1)), idle_ok);
  endtask

  task automatic make_key(input int slot, input int len);
    recent_len[slot] = len;
    for (int i = 0; i < len; i++) recent_keys[slot][i] = 8'($urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    int r, slot, stop;
    stop = sent + items;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      slot = $urandom_range(0, 15);
      if (r < 4) begin
        send_item(KIND_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end else if (r < 9) begin
        // key cut short by a clear
        make_key(slot, $urandom_range(1, 4));
        for (int i = 0; i < recent_len[slot]; i++)
          send_item(KIND_KEY, recent_keys[slot][i], 1'b0, 1'($urandom), 1'b1);
        send_item(KIND_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end else if (r < 40) begin
        send_key(slot, 1'($urandom), r < 20);
      end else begin
        make_key(slot, ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(1, 5));
        send_key(slot, 1'($urandom), r < 80);
      end
    end
  endtask

  logic [31:0] bits_cfg[8]   = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd65536,
                                 32'd64, 32'd100, 32'd65537, 32'd8};
  logic [31:0] probes_cfg[8] = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd32,
                                 32'd3, 32'd33, 32'd5, 32'd2};

  initial begin
    rst_n = 1'b0; start = 1'b0; in_kind = 1'b0; in_key_byte = '0;
    in_last_byte = 1'b0; in_do_insert = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sent = 0;
    for (int s = 0; s < 16; s++) make_key(s, 1);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset sizes, byte extremes, insert then lookup, clear behavior
    recent_keys[0][0] = 8'h00; recent_len[0] = 1;
    recent_keys[1][0] = 8'hFF; recent_len[1] = 1;
    make_key(2, 6);
    send_key(0, 1'b0, 1'b0);
    send_key(0, 1'b1, 1'b0);
    send_key(0, 1'b0, 1'b0);
    send_key(1, 1'b0, 1'b1);
    send_key(1, 1'b1, 1'b1);
    send_key(2, 1'b1, 1'b0);
    send_key(2, 1'b0, 1'b0);
    send_item(KIND_KEY, 8'hA5, 1'b0, 1'b1, 1'b0);
    send_item(KIND_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_key(2, 1'b0, 1'b1);
    send_key(1, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      reg_write(ADDR_BITS, bits_cfg[p]);
      reg_write(ADDR_PROBES, probes_cfg[p]);
      random_phase(150);
      drain();
    end
    reg_write(ADDR_BITS, $urandom);
    reg_write(ADDR_PROBES, $urandom);
    random_phase(150);
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
